### src/rprc_pkg.sv
// Shared types and codes for the rotated point region check block.
// Used by rprc_ctrl, rprc_datapath and rotated_point_region_check.
package rprc_pkg;

  // Item kinds
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_POINT  = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MIN_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_MAX_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CYL_RADIUS  = 3'd2;
  localparam logic [2:0] REG_BOX_HALF_W  = 3'd3;
  localparam logic [2:0] REG_BOX_HALF_L  = 3'd4;
  localparam logic [2:0] REG_MIN_MASS    = 3'd5;
  localparam logic [2:0] REG_MAX_MASS    = 3'd6;
  localparam logic [2:0] REG_REGION_MODE = 3'd7;

  localparam logic MODE_CYLINDER = 1'b0;
  localparam logic MODE_BOX      = 1'b1;

  // Multiplier operand sources
  localparam logic [1:0] MK_QUAT = 2'd0;
  localparam logic [1:0] MK_ROT  = 2'd1;
  localparam logic [1:0] MK_SQ   = 2'd2;

  // Header products, in issue order
  localparam logic [3:0] P_XX = 4'd0;
  localparam logic [3:0] P_YY = 4'd1;
  localparam logic [3:0] P_ZZ = 4'd2;
  localparam logic [3:0] P_SS = 4'd3;
  localparam logic [3:0] P_XY = 4'd4;
  localparam logic [3:0] P_ZS = 4'd5;
  localparam logic [3:0] P_YZ = 4'd6;
  localparam logic [3:0] P_XS = 4'd7;
  localparam logic [3:0] P_XZ = 4'd8;
  localparam logic [3:0] P_YS = 4'd9;
  localparam int unsigned NumHdrProd = 10;

  // Q2.16 one
  localparam logic signed [17:0] ROT_ONE = 18'sd65536;

  typedef struct packed {
    logic signed [31:0] min_height;
    logic signed [31:0] max_height;
    logic [30:0]        cylinder_radius;
    logic [30:0]        box_half_width;
    logic [30:0]        box_half_length;
    logic [31:0]        min_body_mass;
    logic [31:0]        max_body_mass;
    logic               region_mode;
  } cfg_t;

  typedef struct packed {
    logic       cap_hdr;
    logic       cap_pt;
    logic       mul_en;
    logic [1:0] mul_kind;
    logic [3:0] mul_idx;
    logic       prod_wr;
    logic [3:0] prod_idx;
    logic       n2_load;
    logic       set_ident;
    logic       div_init;
    logic       div_step;
    logic       div_last;
    logic [3:0] ent_idx;
    logic       acc_en;
    logic       acc_first;
    logic       acc_last;
    logic [1:0] acc_row;
    logic [1:0] acc_col;
    logic       sq_wr;
    logic [1:0] sq_idx;
    logic       fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n2_zero;
  } ctrl_sts_t;

endpackage

### src/rprc_ctrl.sv
// Sequencer for the rotated point region check: header and point step control.
// Depends on rprc_pkg; drives rprc_datapath through ctrl_cmd_t.
module rprc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rprc_pkg::ctrl_sts_t  sts_i,
  output rprc_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HMUL = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_DIVI = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_PMUL = 3'd5;
  localparam logic [2:0] S_SQ   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [3:0] ent_q, ent_d;
  logic       out_valid_q, out_valid_d;
  logic [3:0] term;

  assign term = cnt_q[3:0] - 4'd1;

  // Step through the item's phases
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ent_d       = ent_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cmd_o.ent_idx = ent_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          if (command_i == rprc_pkg::CMD_HEADER) begin
            cmd_o.cap_hdr = 1'b1;
            state_d       = S_HMUL;
          end else begin
            cmd_o.cap_pt = 1'b1;
            state_d      = S_PMUL;
          end
        end
      end
      S_HMUL: begin
        cmd_o.mul_kind = rprc_pkg::MK_QUAT;
        cmd_o.mul_idx  = cnt_q[3:0];
        cmd_o.mul_en   = (cnt_q < 5'd10);
        cmd_o.prod_wr  = (cnt_q != 5'd0);
        cmd_o.prod_idx = term;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'd10) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.n2_load = 1'b1;
        ent_d         = '0;
        if (sts_i.n2_zero) begin
          cmd_o.set_ident = 1'b1;
          state_d         = S_FIN;
        end else begin
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          cmd_o.div_last = 1'b1;
          if (ent_q == 4'd8) begin
            state_d = S_FIN;
          end else begin
            ent_d   = ent_q + 4'd1;
            state_d = S_DIVI;
          end
        end
      end
      S_PMUL: begin
        cmd_o.mul_kind = rprc_pkg::MK_ROT;
        cmd_o.mul_idx  = cnt_q[3:0];
        cmd_o.mul_en   = (cnt_q < 5'd9);
        cmd_o.acc_en   = (cnt_q != 5'd0);
        case (term)
          4'd0, 4'd1, 4'd2: begin
            cmd_o.acc_row = 2'd0;
            cmd_o.acc_col = 2'(term);
          end
          4'd3, 4'd4, 4'd5: begin
            cmd_o.acc_row = 2'd1;
            cmd_o.acc_col = 2'(term - 4'd3);
          end
          default: begin
            cmd_o.acc_row = 2'd2;
            cmd_o.acc_col = 2'(term - 4'd6);
          end
        endcase
        cmd_o.acc_first = (cmd_o.acc_col == 2'd0);
        cmd_o.acc_last  = (cmd_o.acc_col == 2'd2);
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'd9) begin
          cnt_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.mul_kind = rprc_pkg::MK_SQ;
        cmd_o.mul_idx  = cnt_q[3:0];
        cmd_o.mul_en   = (cnt_q < 5'd3);
        cmd_o.sq_wr    = (cnt_q != 5'd0);
        cmd_o.sq_idx   = term[1:0];
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ent_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ent_q       <= ent_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/rprc_datapath.sv
// Datapath: shared multiplier, rotation matrix, restoring divider, region and mass tests.
// Depends on rprc_pkg; steered by rprc_ctrl.
module rprc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rprc_pkg::ctrl_cmd_t  cmd_i,
  output rprc_pkg::ctrl_sts_t  sts_o,
  input  rprc_pkg::cfg_t       cfg_i,
  input  logic                 command_i,
  input  logic signed [15:0]   quat_x_i,
  input  logic signed [15:0]   quat_y_i,
  input  logic signed [15:0]   quat_z_i,
  input  logic signed [15:0]   quat_scalar_i,
  input  logic signed [31:0]   center_x_i,
  input  logic signed [31:0]   center_y_i,
  input  logic signed [31:0]   center_z_i,
  input  logic [31:0]          body_mass_i,
  input  logic signed [31:0]   local_x_i,
  input  logic signed [31:0]   local_y_i,
  input  logic signed [31:0]   local_z_i,
  output logic                 still_qualified_o,
  output logic                 mass_in_range_o,
  output logic                 point_inside_o
);

  logic                cmd_q;
  logic signed [15:0]  qx_q, qy_q, qz_q, qs_q;
  logic [31:0]         mass_q;
  logic signed [31:0]  loc_q [3];
  logic signed [31:0]  center_q [3];
  logic signed [17:0]  rot_q [9];
  logic signed [31:0]  hp_q [rprc_pkg::NumHdrProd];
  logic [32:0]         n2_q;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mul_q;
  logic [50:0]         rem_q, rem_d;
  logic [48:0]         dvs_q;
  logic [16:0]         quo_q, quo_next;
  logic                neg_q;
  logic                div_ge;
  logic signed [51:0]  acc_q, acc_sum, acc_rnd;
  logic signed [36:0]  w_q [3];
  logic [61:0]         sq_q [3];
  logic                verdict_q, mass_flag_q;
  logic                res_still_q, res_mass_q, res_inside_q;
  logic signed [34:0]  xx, yy, zz, ss, xy, zs, yz, xs, xz, ys;
  logic signed [34:0]  numer;
  logic [33:0]         numer_mag;
  logic [33:0]         n2_sum;
  logic [36:0]         ax, ay;
  logic                mass_ok, pt_inside;
  logic signed [17:0]  rot_new;

  // Header products widened for the numerators
  assign xx = 35'(hp_q[rprc_pkg::P_XX]);
  assign yy = 35'(hp_q[rprc_pkg::P_YY]);
  assign zz = 35'(hp_q[rprc_pkg::P_ZZ]);
  assign ss = 35'(hp_q[rprc_pkg::P_SS]);
  assign xy = 35'(hp_q[rprc_pkg::P_XY]);
  assign zs = 35'(hp_q[rprc_pkg::P_ZS]);
  assign yz = 35'(hp_q[rprc_pkg::P_YZ]);
  assign xs = 35'(hp_q[rprc_pkg::P_XS]);
  assign xz = 35'(hp_q[rprc_pkg::P_XZ]);
  assign ys = 35'(hp_q[rprc_pkg::P_YS]);

  assign n2_sum        = 34'(xx + yy + zz + ss);
  assign sts_o.n2_zero = (n2_sum == '0);

  // Select the numerator of the entry under division
  always_comb begin
    case (cmd_i.ent_idx)
      4'd0:    numer = -xx + yy - zz + ss;
      4'd1:    numer = -((xy - zs) <<< 1);
      4'd2:    numer = (yz + xs) <<< 1;
      4'd3:    numer = -((xy + zs) <<< 1);
      4'd4:    numer = xx - yy - zz + ss;
      4'd5:    numer = -((xz - ys) <<< 1);
      4'd6:    numer = (yz - xs) <<< 1;
      4'd7:    numer = -((xz + ys) <<< 1);
      default: numer = -xx - yy + zz + ss;
    endcase
    numer_mag = numer[34] ? 34'(-numer) : 34'(numer);
  end

  // World coordinate magnitudes
  assign ax = w_q[0][36] ? 37'(-w_q[0]) : 37'(w_q[0]);
  assign ay = w_q[1][36] ? 37'(-w_q[1]) : 37'(w_q[1]);

  // Pick multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_kind)
      rprc_pkg::MK_QUAT: begin
        case (cmd_i.mul_idx)
          rprc_pkg::P_XX: begin mul_a = 33'(qx_q); mul_b = 33'(qx_q); end
          rprc_pkg::P_YY: begin mul_a = 33'(qy_q); mul_b = 33'(qy_q); end
          rprc_pkg::P_ZZ: begin mul_a = 33'(qz_q); mul_b = 33'(qz_q); end
          rprc_pkg::P_SS: begin mul_a = 33'(qs_q); mul_b = 33'(qs_q); end
          rprc_pkg::P_XY: begin mul_a = 33'(qx_q); mul_b = 33'(qy_q); end
          rprc_pkg::P_ZS: begin mul_a = 33'(qz_q); mul_b = 33'(qs_q); end
          rprc_pkg::P_YZ: begin mul_a = 33'(qy_q); mul_b = 33'(qz_q); end
          rprc_pkg::P_XS: begin mul_a = 33'(qx_q); mul_b = 33'(qs_q); end
          rprc_pkg::P_XZ: begin mul_a = 33'(qx_q); mul_b = 33'(qz_q); end
          default:        begin mul_a = 33'(qy_q); mul_b = 33'(qs_q); end
        endcase
      end
      rprc_pkg::MK_ROT: begin
        mul_a = 33'(rot_q[cmd_i.mul_idx]);
        case (cmd_i.mul_idx)
          4'd0, 4'd3, 4'd6: mul_b = 33'(loc_q[0]);
          4'd1, 4'd4, 4'd7: mul_b = 33'(loc_q[1]);
          default:          mul_b = 33'(loc_q[2]);
        endcase
      end
      rprc_pkg::MK_SQ: begin
        case (cmd_i.mul_idx[1:0])
          2'd0:    mul_a = {2'b00, ax[30:0]};
          2'd1:    mul_a = {2'b00, ay[30:0]};
          default: mul_a = {2'b00, cfg_i.cylinder_radius};
        endcase
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider step: one quotient bit per cycle
  assign div_ge   = (rem_q >= {2'b00, dvs_q});
  assign rem_d    = div_ge ? rem_q - {2'b00, dvs_q} : rem_q;
  assign quo_next = {quo_q[15:0], div_ge};
  assign rot_new  = neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});

  // Accumulate one row of the rotated point
  assign acc_sum = (cmd_i.acc_first ? 52'sd0 : acc_q) + $signed(mul_q[51:0]);
  assign acc_rnd = (acc_sum + 52'sd32768) >>> 16;

  // Region and mass tests
  always_comb begin
    mass_ok   = !(mass_q < cfg_i.min_body_mass) && !(mass_q > cfg_i.max_body_mass);
    pt_inside = 1'b1;
    if ((w_q[2] < 37'(cfg_i.min_height)) || (w_q[2] > 37'(cfg_i.max_height))) begin
      pt_inside = 1'b0;
    end else if (cfg_i.region_mode == rprc_pkg::MODE_CYLINDER) begin
      if ((ax > {6'b0, cfg_i.cylinder_radius}) || (ay > {6'b0, cfg_i.cylinder_radius})) begin
        pt_inside = 1'b0;
      end else if (({1'b0, sq_q[0]} + {1'b0, sq_q[1]}) > {1'b0, sq_q[2]}) begin
        pt_inside = 1'b0;
      end
    end else begin
      if ((ax > {6'b0, cfg_i.box_half_width}) || (ay > {6'b0, cfg_i.box_half_length})) begin
        pt_inside = 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hdr) begin
      qx_q   <= quat_x_i;
      qy_q   <= quat_y_i;
      qz_q   <= quat_z_i;
      qs_q   <= quat_scalar_i;
      mass_q <= body_mass_i;
    end
    if (cmd_i.cap_hdr || cmd_i.cap_pt) begin
      cmd_q <= command_i;
    end
    if (cmd_i.cap_pt) begin
      loc_q[0] <= local_x_i;
      loc_q[1] <= local_y_i;
      loc_q[2] <= local_z_i;
    end
    if (cmd_i.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    if (cmd_i.prod_wr) begin
      hp_q[cmd_i.prod_idx] <= mul_q[31:0];
    end
    if (cmd_i.n2_load) begin
      n2_q <= n2_sum[32:0];
    end
    if (cmd_i.div_init) begin
      rem_q <= 51'({numer_mag, 16'b0}) + 51'(n2_q >> 1);
      dvs_q <= {n2_q, 16'b0};
      quo_q <= '0;
      neg_q <= numer[34];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvs_q <= dvs_q >> 1;
      quo_q <= quo_next;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_sum;
      if (cmd_i.acc_last) begin
        w_q[cmd_i.acc_row] <= 37'(acc_rnd) + 37'(center_q[cmd_i.acc_row]);
      end
    end
    if (cmd_i.sq_wr) begin
      sq_q[cmd_i.sq_idx] <= mul_q[61:0];
    end
    if (cmd_i.fin) begin
      if (cmd_q == rprc_pkg::CMD_HEADER) begin
        res_still_q  <= mass_ok;
        res_mass_q   <= mass_ok;
        res_inside_q <= 1'b1;
      end else begin
        res_still_q  <= verdict_q & pt_inside;
        res_mass_q   <= mass_flag_q;
        res_inside_q <= pt_inside;
      end
    end
  end

  // Body state: matrix, center and sticky flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        rot_q[i] <= ((i % 4) == 0) ? rprc_pkg::ROT_ONE : 18'sd0;
      end
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= '0;
      end
      verdict_q   <= 1'b1;
      mass_flag_q <= 1'b1;
    end else begin
      if (cmd_i.cap_hdr) begin
        center_q[0] <= center_x_i;
        center_q[1] <= center_y_i;
        center_q[2] <= center_z_i;
      end
      if (cmd_i.set_ident) begin
        for (int i = 0; i < 9; i++) begin
          rot_q[i] <= ((i % 4) == 0) ? rprc_pkg::ROT_ONE : 18'sd0;
        end
      end
      if (cmd_i.div_step && cmd_i.div_last) begin
        rot_q[cmd_i.ent_idx] <= rot_new;
      end
      if (cmd_i.fin) begin
        if (cmd_q == rprc_pkg::CMD_HEADER) begin
          verdict_q   <= mass_ok;
          mass_flag_q <= mass_ok;
        end else if (!pt_inside) begin
          verdict_q <= 1'b0;
        end
      end
    end
  end

  assign still_qualified_o = res_still_q;
  assign mass_in_range_o   = res_mass_q;
  assign point_inside_o    = res_inside_q;

endmodule

### src/rotated_point_region_check.sv
// Top level of the rotated point region check: register file and block wiring.
// Depends on rprc_pkg, rprc_ctrl and rprc_datapath.
//
//  Channel   Signals                          Direction  Handshake
//  input     command_i .. local_z_i           in         in_valid_i / in_ready_o
//  result    still_qualified_o .. point_inside_o  out    out_valid_o / out_ready_i
//  config    psel, penable, pwrite, paddr...  in/out     APB, pready tied high
//
// A point passes through capture, nine row products and three squares through the one
// shared 33x33 multiplier, and finish. A header runs the quaternion products, then
// the restoring divider: per matrix entry a setup step and 17 quotient steps, for
// nine entries; a zero quaternion header skips the divider and loads the identity.
// Reset loads the identity matrix, a zero center and both flags set.
// A new word is taken while the previous result waits; the finish step stalls
// until the output register is free.
module rotated_point_region_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_scalar_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [31:0]        body_mass_i,
  input  logic signed [31:0] local_x_i,
  input  logic signed [31:0] local_y_i,
  input  logic signed [31:0] local_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               still_qualified_o,
  output logic               mass_in_range_o,
  output logic               point_inside_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rprc_pkg::cfg_t      cfg_q;
  rprc_pkg::ctrl_cmd_t cmd;
  rprc_pkg::ctrl_sts_t sts;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_body_mass: 32'hFFFF_FFFF, default: '0};
    end else if (wr_en) begin
      case (paddr[4:2])
        rprc_pkg::REG_MIN_HEIGHT:  cfg_q.min_height      <= pwdata;
        rprc_pkg::REG_MAX_HEIGHT:  cfg_q.max_height      <= pwdata;
        rprc_pkg::REG_CYL_RADIUS:  cfg_q.cylinder_radius <= pwdata[30:0];
        rprc_pkg::REG_BOX_HALF_W:  cfg_q.box_half_width  <= pwdata[30:0];
        rprc_pkg::REG_BOX_HALF_L:  cfg_q.box_half_length <= pwdata[30:0];
        rprc_pkg::REG_MIN_MASS:    cfg_q.min_body_mass   <= pwdata;
        rprc_pkg::REG_MAX_MASS:    cfg_q.max_body_mass   <= pwdata;
        default:                   cfg_q.region_mode     <= pwdata[0];
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[4:2])
      rprc_pkg::REG_MIN_HEIGHT:  prdata = cfg_q.min_height;
      rprc_pkg::REG_MAX_HEIGHT:  prdata = cfg_q.max_height;
      rprc_pkg::REG_CYL_RADIUS:  prdata = {1'b0, cfg_q.cylinder_radius};
      rprc_pkg::REG_BOX_HALF_W:  prdata = {1'b0, cfg_q.box_half_width};
      rprc_pkg::REG_BOX_HALF_L:  prdata = {1'b0, cfg_q.box_half_length};
      rprc_pkg::REG_MIN_MASS:    prdata = cfg_q.min_body_mass;
      rprc_pkg::REG_MAX_MASS:    prdata = cfg_q.max_body_mass;
      default:                   prdata = {31'b0, cfg_q.region_mode};
    endcase
  end

  rprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rprc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_i             (cfg_q),
    .command_i         (command_i),
    .quat_x_i          (quat_x_i),
    .quat_y_i          (quat_y_i),
    .quat_z_i          (quat_z_i),
    .quat_scalar_i     (quat_scalar_i),
    .center_x_i        (center_x_i),
    .center_y_i        (center_y_i),
    .center_z_i        (center_z_i),
    .body_mass_i       (body_mass_i),
    .local_x_i         (local_x_i),
    .local_y_i         (local_y_i),
    .local_z_i         (local_z_i),
    .still_qualified_o (still_qualified_o),
    .mass_in_range_o   (mass_in_range_o),
    .point_inside_o    (point_inside_o)
  );

endmodule
